/* design/mcep_pkg.sv */
// Shared types and constants for the mode-change element parser.
package mcep_pkg;

    // Parameter bits kept from a tuple: link set uses bits 28..0
    localparam int PARAM_W = 29;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_DELAY = 2'd1,
        KIND_LINK  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_MISMATCH = 2'd1,
        ST_TRUNC    = 2'd2
    } status_t;

    // Configuration register indexes
    localparam logic REG_NPCA  = 1'b0;
    localparam logic REG_EMLSR = 1'b1;

    // One parsed tuple, as passed from the parser to the output side
    typedef struct packed {
        logic [7:0]         hdr;
        kind_t              kind;
        logic [3:0]         len;
        logic [PARAM_W-1:0] params;
        status_t            status;
        logic               last;
    } rec_t;

endpackage

/* design/mode_change_element_parser.sv */
// Top level of the mode-change element parser.
//
// Bytes of a mode-change information field enter on the s_axis channel, one
// per transaction, with tlast on the final byte of the field. Each complete
// mode tuple (or a tuple cut short by tlast) yields one transaction on
// m_axis carrying the header fields, the parameter kind and values, a status
// code and tlast marking the tuple that ends the field. Header and length
// bytes of a parameterized tuple produce nothing on their own.
// The two mode ids are written through cfg_wen/cfg_index/cfg_wdata; the user
// must do so only while the block is idle, which the block does not enforce.
// Index 0 is the delay-set id, index 1 the link-set id. Throughput: one
// byte per cycle while the queue has room. The parser folds each byte
// into its tuple state and pushes finished tuples into a QUEUE_DEPTH-entry
// queue; an output register drains the queue. A result passes through the
// queue and the output register to m_axis, and holds there until taken.
// When the receiver stalls, results back up in the output register and the
// queue; s_axis_tready drops only once the queue is full.
// Reset clears the parse state, empties the queue and output register, and
// restores the mode ids to 0 and 1.
module mode_change_element_parser #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_wen,
    input  logic        cfg_index,
    input  logic [5:0]  cfg_wdata,
    // input byte stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // last_byte
    // parsed tuple stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [5:0] mode_id, [6] mode_enable, [7] mode_update, [11:8] param_length,
    // [27:12] link_bitmap, [33:28] first_delay, [39:34] second_delay,
    // [40] coex_active, [47:41] zero
    output logic [47:0] m_axis_tdata,
    output logic [3:0]  m_axis_tuser,   // [1:0] param_kind, [3:2] status
    output logic        m_axis_tlast    // last_tuple
);
    import mcep_pkg::*;

    rec_t        push_rec;
    rec_t        head;
    logic        push;
    logic        q_full;
    logic        q_empty;
    logic        pop;
    logic [40:0] out_data;

    // Parse bytes; stall only when the queue has no free slot
    mcep_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_byte   (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .q_full    (q_full),
        .push      (push),
        .rec       (push_rec)
    );

    // Decouple the parser from downstream stalls
    mcep_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_rec (push_rec),
        .full     (q_full),
        .pop      (pop),
        .empty    (q_empty),
        .head     (head)
    );

    // Format and hold the result until the receiver takes it
    mcep_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .head      (head),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_data),
        .out_user  (m_axis_tuser),
        .out_last  (m_axis_tlast)
    );

    // Pad the result to whole bytes
    assign m_axis_tdata = {7'b0, out_data};

endmodule

/* design/mcep_front.sv */
// Byte parser: classifies tuple headers and collects parameter bytes.
module mcep_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_wen,
    input  logic          cfg_index,
    input  logic [5:0]    cfg_wdata,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [7:0]    in_byte,
    input  logic          in_last,
    input  logic          q_full,
    output logic          push,
    output mcep_pkg::rec_t rec
);
    import mcep_pkg::*;

    typedef enum logic [2:0] {
        PH_HEADER = 3'b001,
        PH_LENGTH = 3'b010,
        PH_PARAMS = 3'b100
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [7:0]         hdr_reg, hdr_next;
    kind_t              kind_reg, kind_next;
    logic [3:0]         len_reg, len_next;
    logic [1:0]         cnt_reg, cnt_next;
    logic [PARAM_W-1:0] shift_reg, shift_next;
    logic [5:0]         npca_reg;
    logic [5:0]         emlsr_reg;

    logic               accept;
    kind_t              kind_in;
    logic [PARAM_W-1:0] lane;
    logic [PARAM_W-1:0] shift_new;
    logic [1:0]         last_idx;
    logic [3:0]         need;

    assign in_ready = !q_full;
    assign accept   = in_valid && !q_full;

    always_comb
    begin
        if (in_byte[6] && (in_byte[5:0] == npca_reg))
            kind_in = KIND_DELAY;
        else if (in_byte[6] && (in_byte[5:0] == emlsr_reg))
            kind_in = KIND_LINK;
        else
            kind_in = KIND_NONE;
    end

    // Place the incoming byte in its little-endian lane
    always_comb
    begin
        case (cnt_reg)
            2'd0:    lane = {{(PARAM_W-8){1'b0}}, in_byte};
            2'd1:    lane = {{(PARAM_W-16){1'b0}}, in_byte, 8'b0};
            2'd2:    lane = {{(PARAM_W-24){1'b0}}, in_byte, 16'b0};
            default: lane = {in_byte[PARAM_W-25:0], 24'b0};
        endcase
    end

    assign shift_new = shift_reg | lane;
    assign last_idx  = (kind_reg == KIND_LINK) ? 2'd3 : 2'd1;
    assign need      = (kind_reg == KIND_LINK) ? 4'd4 : 4'd2;

    always_comb
    begin
        phase_next = phase_reg;
        hdr_next   = hdr_reg;
        kind_next  = kind_reg;
        len_next   = len_reg;
        cnt_next   = cnt_reg;
        shift_next = shift_reg;
        push       = 1'b0;
        rec.hdr    = hdr_reg;
        rec.kind   = kind_reg;
        rec.len    = len_reg;
        rec.params = '0;
        rec.status = ST_OK;
        rec.last   = in_last;

        case (phase_reg)
            PH_HEADER:
            begin
                if (accept)
                begin
                    hdr_next   = in_byte;
                    kind_next  = kind_in;
                    len_next   = 4'd0;
                    cnt_next   = 2'd0;
                    shift_next = '0;
                    rec.hdr    = in_byte;
                    rec.kind   = kind_in;
                    rec.len    = 4'd0;
                    if (kind_in == KIND_NONE)
                    begin
                        push = 1'b1;
                    end
                    else if (in_last)
                    begin
                        push       = 1'b1;
                        rec.status = ST_TRUNC;
                    end
                    else
                    begin
                        phase_next = PH_LENGTH;
                    end
                end
            end
            PH_LENGTH:
            begin
                if (accept)
                begin
                    len_next = in_byte[3:0];
                    rec.len  = in_byte[3:0];
                    if (in_last)
                    begin
                        push       = 1'b1;
                        rec.status = ST_TRUNC;
                        phase_next = PH_HEADER;
                    end
                    else
                    begin
                        phase_next = PH_PARAMS;
                        cnt_next   = 2'd0;
                        shift_next = '0;
                    end
                end
            end
            PH_PARAMS:
            begin
                if (accept)
                begin
                    if (cnt_reg >= last_idx)
                    begin
                        // tuple complete
                        push       = 1'b1;
                        rec.params = shift_new;
                        rec.status = (len_reg == need) ? ST_OK : ST_MISMATCH;
                        phase_next = PH_HEADER;
                    end
                    else
                    begin
                        cnt_next   = cnt_reg + 2'd1;
                        shift_next = shift_new;
                        if (in_last)
                        begin
                            push       = 1'b1;
                            rec.status = ST_TRUNC;
                            phase_next = PH_HEADER;
                        end
                    end
                end
            end
            default:
            begin
                phase_next = PH_HEADER;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            hdr_reg   <= 8'd0;
            kind_reg  <= KIND_NONE;
            len_reg   <= 4'd0;
            cnt_reg   <= 2'd0;
            shift_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            hdr_reg   <= hdr_next;
            kind_reg  <= kind_next;
            len_reg   <= len_next;
            cnt_reg   <= cnt_next;
            shift_reg <= shift_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            npca_reg  <= 6'd0;
            emlsr_reg <= 6'd1;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                REG_NPCA:  npca_reg  <= cfg_wdata;
                REG_EMLSR: emlsr_reg <= cfg_wdata;
                default:   npca_reg  <= npca_reg;
            endcase
        end
    end

endmodule

/* design/mcep_queue.sv */
// Short tuple queue between the parser and the output stage.
module mcep_queue #(
    parameter int DEPTH = 2
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  mcep_pkg::rec_t push_rec,
    output logic           full,
    input  logic           pop,
    output logic           empty,
    output mcep_pkg::rec_t head
);
    import mcep_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);

    rec_t          mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

/* design/mcep_back.sv */
// Output stage: formats a queued tuple into result fields and holds it.
module mcep_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_empty,
    input  mcep_pkg::rec_t head,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [40:0]    out_data,
    output logic [3:0]     out_user,
    output logic           out_last
);
    import mcep_pkg::*;

    logic        valid_reg;
    logic [40:0] data_reg;
    logic [3:0]  user_reg;
    logic        last_reg;

    logic [15:0] bitmap;
    logic [5:0]  delay1;
    logic [5:0]  delay2;
    logic        coex;

    assign pop = !q_empty && (!valid_reg || out_ready);

    always_comb
    begin
        bitmap = 16'd0;
        delay1 = 6'd0;
        delay2 = 6'd0;
        coex   = 1'b0;
        case (head.kind)
            KIND_DELAY:
            begin
                delay1 = head.params[5:0];
                delay2 = head.params[11:6];
            end
            KIND_LINK:
            begin
                bitmap = head.params[15:0];
                delay1 = head.params[21:16];
                delay2 = head.params[27:22];
                coex   = head.params[28];
            end
            default:
            begin
                bitmap = 16'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (pop)
            valid_reg <= 1'b1;
        else if (out_ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            data_reg <= {coex, delay2, delay1, bitmap, head.len, head.hdr};
            user_reg <= {head.status, head.kind};
            last_reg <= head.last;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_user  = user_reg;
    assign out_last  = last_reg;

endmodule

/* bench/tb_mode_change_element_parser.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the mode-change element parser: directed tuples, then random frames.
module tb_mode_change_element_parser;
    import mcep_pkg::*;

    // Cycles to let pass once nothing is expected: the output side holds a queue and an output register
    localparam int DRAIN_CYCLES = 6;
    // Cycles without any transaction on either side before the run is abandoned
    localparam int STALL_LIMIT  = 2000;
    // Limit log volume on a badly broken block
    localparam int MAX_REPORTS  = 100;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_LENGTH,
        PH_PARAMS
    } phase_t;

    // One parsed tuple as the block should present it
    typedef struct {
        logic [5:0]  mode_id;
        logic        mode_enable;
        logic        mode_update;
        kind_t       param_kind;
        logic [3:0]  param_length;
        logic [15:0] link_bitmap;
        logic [5:0]  first_delay;
        logic [5:0]  second_delay;
        logic        coex_active;
        status_t     status;
        logic        last_tuple;
    } tuple_t;

    // Block inputs, all known from time zero
    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        cfg_wen       = 1'b0;
    logic        cfg_index     = REG_NPCA;
    logic [5:0]  cfg_wdata     = 6'd0;
    logic        s_axis_tvalid = 1'b0;
    logic [7:0]  s_axis_tdata  = 8'd0;
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tready = 1'b0;

    // Block outputs
    logic        s_axis_tready;
    logic        m_axis_tvalid;
    logic [47:0] m_axis_tdata;
    logic [3:0]  m_axis_tuser;
    logic        m_axis_tlast;

    // Parser state as this bench tracks it, with its own copy of the mode ids
    phase_t      p_phase  = PH_HEADER;
    logic [7:0]  p_header = 8'd0;
    logic [3:0]  p_length = 4'd0;
    kind_t       p_kind   = KIND_NONE;
    logic [1:0]  p_seen   = 2'd0;
    logic [31:0] p_shift  = 32'd0;
    logic [5:0]  cur_npca  = 6'd0;
    logic [5:0]  cur_emlsr = 6'd1;

    tuple_t pending_tuples[$];
    tuple_t next_tuple;

    int err_cnt     = 0;
    int bytes_sent  = 0;
    int idle_cycles = 0;
    int sink_hold   = 0;
    int sink_gap;
    // Set to run a stretch with no idling on either side
    bit calm        = 1'b0;

    mode_change_element_parser dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wen       (cfg_wen),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Idle length for either side: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Build the tuple the block reports from the tracked state; parameter
    // fields stay zero unless the parameter bytes all arrived
    function automatic tuple_t make_tuple(status_t st, logic last, bit with_params);
        tuple_t t;
        t.mode_id      = p_header[5:0];
        t.mode_enable  = p_header[6];
        t.mode_update  = p_header[7];
        t.param_kind   = p_kind;
        t.param_length = p_length;
        t.link_bitmap  = 16'd0;
        t.first_delay  = 6'd0;
        t.second_delay = 6'd0;
        t.coex_active  = 1'b0;
        if (with_params && p_kind == KIND_DELAY)
        begin
            t.first_delay  = p_shift[5:0];
            t.second_delay = p_shift[11:6];
        end
        else if (with_params && p_kind == KIND_LINK)
        begin
            t.link_bitmap  = p_shift[15:0];
            t.first_delay  = p_shift[21:16];
            t.second_delay = p_shift[27:22];
            t.coex_active  = p_shift[28];
        end
        t.status     = st;
        t.last_tuple = last;
        return t;
    endfunction

    task automatic clear_tuple();
        p_phase  = PH_HEADER;
        p_header = 8'd0;
        p_length = 4'd0;
        p_kind   = KIND_NONE;
        p_seen   = 2'd0;
        p_shift  = 32'd0;
    endtask

    // Append one expected tuple behind those already waiting
    task automatic queue_expected(input tuple_t t);
        pending_tuples.insert(pending_tuples.size(), t);
    endtask

    // Fold one accepted byte into the tracked state; queue the tuple it completes
    task automatic predict_tuple(input logic [7:0] b, input logic l);
        int need;
        int pos;
        case (p_phase)
            PH_HEADER:
            begin
                clear_tuple();
                p_header = b;
                // Delay-set id wins when both ids are equal
                if (b[6] && b[5:0] == cur_npca)
                    p_kind = KIND_DELAY;
                else if (b[6] && b[5:0] == cur_emlsr)
                    p_kind = KIND_LINK;
                if (p_kind == KIND_NONE)
                begin
                    queue_expected(make_tuple(ST_OK, l, 1'b0));
                    clear_tuple();
                end
                else if (l)
                begin
                    queue_expected(make_tuple(ST_TRUNC, 1'b1, 1'b0));
                    clear_tuple();
                end
                else
                    p_phase = PH_LENGTH;
            end
            PH_LENGTH:
            begin
                p_length = b[3:0];
                if (l)
                begin
                    queue_expected(make_tuple(ST_TRUNC, 1'b1, 1'b0));
                    clear_tuple();
                end
                else
                begin
                    p_phase = PH_PARAMS;
                    p_seen  = 2'd0;
                    p_shift = 32'd0;
                end
            end
            default:
            begin
                // Byte count comes from the kind; the length field is only checked
                need    = (p_kind == KIND_LINK) ? 4 : 2;
                p_shift = p_shift | ({24'd0, b} << (8 * p_seen));
                pos     = p_seen + 1;
                if (pos >= need)
                begin
                    queue_expected(make_tuple(
                        (p_length == need) ? ST_OK : ST_MISMATCH, l, 1'b1));
                    clear_tuple();
                end
                else
                begin
                    p_seen = pos[1:0];
                    if (l)
                    begin
                        queue_expected(make_tuple(ST_TRUNC, 1'b1, 1'b0));
                        clear_tuple();
                    end
                end
            end
        endcase
    endtask

    // Offer one byte, hold it until the transaction completes, then predict.
    // tvalid is left high so back-to-back bytes need no second assignment.
    task automatic send_byte(input logic [7:0] b, input logic l);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= l;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_tuple(b, l);
        bytes_sent++;
    endtask

    // Drop tvalid and hold until every queued tuple has come out and the
    // pipeline has had time to settle
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_tuples.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write both mode ids on consecutive edges; call only while idle
    task automatic write_regs(input logic [5:0] npca, input logic [5:0] emlsr);
        cfg_wen   <= 1'b1;
        cfg_index <= REG_NPCA;
        cfg_wdata <= npca;
        @(posedge clk);
        cur_npca = npca;
        cfg_index <= REG_EMLSR;
        cfg_wdata <= emlsr;
        @(posedge clk);
        cur_emlsr = emlsr;
        cfg_wen <= 1'b0;
    endtask

    // One well-formed tuple with random content; it may end the frame or
    // get cut short by the end marker
    task automatic send_random_tuple();
        logic [7:0] tup [6];
        logic [7:0] lenb;
        logic [5:0] id;
        logic       upd;
        int         sel;
        int         n_par;
        int         total;
        int         last_at;
        int         i;
        sel = $urandom_range(0, 3);
        upd = 1'($urandom_range(0, 1));
        id  = 6'($urandom);
        case (sel)
            0:       tup[0] = {upd, 1'b1, cur_npca};
            1:       tup[0] = {upd, 1'b1, cur_emlsr};
            2:       tup[0] = {upd, 1'b0, id};
            default: tup[0] = 8'($urandom);
        endcase
        if (tup[0][6] && tup[0][5:0] == cur_npca)
            n_par = 2;
        else if (tup[0][6] && tup[0][5:0] == cur_emlsr)
            n_par = 4;
        else
            n_par = 0;
        total = (n_par == 0) ? 1 : n_par + 2;
        if (n_par > 0)
        begin
            lenb = 8'($urandom);
            // Mostly a matching length, upper bits random either way
            if ($urandom_range(0, 4) != 0)
                tup[1] = {lenb[7:4], n_par[3:0]};
            else
                tup[1] = lenb;
            for (i = 2; i < total; i++)
                tup[i] = 8'($urandom);
        end
        last_at = -1;
        if ($urandom_range(0, 5) == 0)
        begin
            if (total > 1 && $urandom_range(0, 3) == 0)
                last_at = $urandom_range(0, total - 2);
            else
                last_at = total - 1;
        end
        for (i = 0; i < total; i++)
        begin
            send_byte(tup[i], i == last_at);
            if (i == last_at)
                break;
        end
    endtask

    // A short frame of random bytes; the closing end marker resyncs the parser
    task automatic send_garbage_frame();
        int n;
        int i;
        n = $urandom_range(1, 6);
        for (i = 0; i < n; i++)
            send_byte(8'($urandom), (i == n - 1) || ($urandom_range(0, 7) == 0));
    endtask

    // Header fields, both parameter sets with all-ones content, tuples
    // without parameters, end marker on complete tuples (reset ids 0 and 1)
    task automatic test_header_fields();
        send_byte(8'h80, 1'b0);
        send_byte(8'h40, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'hc1, 1'b0);
        send_byte(8'h04, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'hff, 1'b1);
        send_byte(8'hbf, 1'b1);
    endtask

    // Length mismatch, then truncation at header, length and parameter bytes
    task automatic test_length_and_truncation();
        send_byte(8'h40, 1'b0);
        send_byte(8'h0f, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h40, 1'b1);
        send_byte(8'h41, 1'b0);
        send_byte(8'h04, 1'b1);
        send_byte(8'h41, 1'b0);
        send_byte(8'h04, 1'b0);
        send_byte(8'ha5, 1'b0);
        send_byte(8'h5a, 1'b1);
    endtask

    // Both ids equal: the matching tuple must take the delay set
    task automatic test_equal_ids();
        wait_idle();
        write_regs(6'd63, 6'd63);
        send_byte(8'h7f, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b1);
    endtask

    // Swap the ids after the header: the kind taken at the header must hold
    task automatic test_write_during_tuple();
        wait_idle();
        write_regs(6'd5, 6'd6);
        send_byte(8'h45, 1'b0);
        wait_idle();
        write_regs(6'd6, 6'd5);
        send_byte(8'h02, 1'b0);
        send_byte(8'h3c, 1'b0);
        send_byte(8'h0f, 1'b1);
    endtask

    // Random frames under one id setting; now and then drain fully before going on
    task automatic test_random_frames(input logic [5:0] npca, input logic [5:0] emlsr,
                                      input bit quiet, input int n_bytes);
        int stop;
        wait_idle();
        write_regs(npca, emlsr);
        calm = quiet;
        stop = bytes_sent + n_bytes;
        while (bytes_sent < stop)
        begin
            if ($urandom_range(0, 99) < 8)
                send_garbage_frame();
            else
                send_random_tuple();
            if ($urandom_range(0, 149) == 0)
                wait_idle();
        end
        calm = 1'b0;
    endtask

    task automatic check_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
        if (exp_v !== act_v)
        begin
            err_cnt++;
            if (err_cnt <= MAX_REPORTS)
                $display("%0t: %s expected %0h actual %0h", $time, name, exp_v, act_v);
        end
    endtask

    // Receiver: random stalls on m_axis tready
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (sink_hold > 0)
        begin
            sink_hold     <= sink_hold - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            sink_gap = pick_gap();
            if (sink_gap == 0)
                m_axis_tready <= 1'b1;
            else
            begin
                m_axis_tready <= 1'b0;
                sink_hold     <= sink_gap - 1;
            end
        end
    end

    // Compare each output transaction with the oldest expected tuple
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_tuples.size() == 0)
            begin
                err_cnt++;
                if (err_cnt <= MAX_REPORTS)
                    $display("%0t: tuple expected none actual tdata %h tuser %h",
                             $time, m_axis_tdata, m_axis_tuser);
            end
            else
            begin
                next_tuple = pending_tuples.pop_front();
                check_field("mode_id", 16'(next_tuple.mode_id),
                            16'(m_axis_tdata[5:0]));
                check_field("mode_enable", 16'(next_tuple.mode_enable),
                            16'(m_axis_tdata[6]));
                check_field("mode_update", 16'(next_tuple.mode_update),
                            16'(m_axis_tdata[7]));
                check_field("param_length", 16'(next_tuple.param_length),
                            16'(m_axis_tdata[11:8]));
                check_field("link_bitmap", next_tuple.link_bitmap,
                            m_axis_tdata[27:12]);
                check_field("first_delay", 16'(next_tuple.first_delay),
                            16'(m_axis_tdata[33:28]));
                check_field("second_delay", 16'(next_tuple.second_delay),
                            16'(m_axis_tdata[39:34]));
                check_field("coex_active", 16'(next_tuple.coex_active),
                            16'(m_axis_tdata[40]));
                check_field("tdata_pad", 16'd0, 16'(m_axis_tdata[47:41]));
                check_field("param_kind", 16'(next_tuple.param_kind),
                            16'(m_axis_tuser[1:0]));
                check_field("status", 16'(next_tuple.status),
                            16'(m_axis_tuser[3:2]));
                check_field("last_tuple", 16'(next_tuple.last_tuple),
                            16'(m_axis_tlast));
            end
        end
    end

    // Watchdog: abandon the run when no transaction moves for too long
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_header_fields();
        test_length_and_truncation();
        test_equal_ids();
        test_write_during_tuple();

        // Id settings with the extremes first, then a random pair
        test_random_frames(6'd0,  6'd1,  1'b1, 250);
        test_random_frames(6'd63, 6'd0,  1'b0, 350);
        test_random_frames(6'd0,  6'd63, 1'b0, 350);
        test_random_frames(6'd63, 6'd63, 1'b0, 250);
        test_random_frames(6'd0,  6'd0,  1'b0, 200);
        test_random_frames(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                           1'b0, 550);

        // Drain: every expected tuple out, then a few quiet cycles
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_cnt == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
